@@ rtl/hlt_pkg.sv @@
// Package for the hierarchical lock table: sizes, request and response types.
// No dependencies.
package hlt_pkg;
  localparam int TableDepth = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int KeyBits = 64;
  localparam int NumTypes = 4;
  localparam int LimW = 6;

  typedef enum logic [1:0] {
    KIND_LOCK = 2'd0, KIND_REL_ONE = 2'd1, KIND_REL_ALL = 2'd2, KIND_ABORT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_REFUSED = 2'd1, ST_NOT_HELD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_PAGE = 2'd0, CFG_REL = 2'd1, CFG_DB = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BS_IDLE, BS_SCAN, BS_APPLY, BS_OUT
  } bstate_e;

  typedef struct packed {
    logic [1:0]   kind;
    logic [14:0]  owner_id;
    logic [1:0]   lock_type;
    logic         lock_mode;
    logic [63:0]  lock_key;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot;
    logic [5:0] freed_count;
  } rsp_t;

  // classified request passed from front to back
  typedef struct packed {
    req_t req;
    logic budget_ok;
  } cmd_t;
endpackage

@@ rtl/hlt_if.sv @@
// Valid/ready channel interfaces carrying a req_t or rsp_t payload.
// Depends on hlt_pkg for the payload types.
interface hlt_req_if import hlt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hlt_rsp_if import hlt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hlt_front.sv @@
// Front end: accepts request beats, masks the key and checks type budgets.
// Depends on hlt_pkg.
module hlt_front import hlt_pkg::*; (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_data_i,
  input  logic [NumTypes-1:0]  budget_zero_i,
  input  logic                 q_ready_i,
  output logic                 q_valid_o,
  output cmd_t                 q_data_o
);
  // budgets change while the back end is busy; the queue holds one command,
  // so the check made here sees the budgets left by all earlier requests only
  // when nothing is pending downstream (enforced through q_ready_i)
  logic ok;
  always_comb begin
    ok = 1'b1;
    for (int t = 0; t < NumTypes; t++) begin
      if (t <= int'(in_data_i.lock_type) && budget_zero_i[t]) ok = 1'b0;
    end
  end
  assign in_ready_o = q_ready_i;
  assign q_valid_o = in_valid_i;
  always_comb begin
    q_data_o.req = in_data_i;
    q_data_o.req.lock_key = in_data_i.lock_key & {KeyBits{1'b1}};
    q_data_o.budget_ok = ok;
  end
endmodule

@@ rtl/hlt_queue.sv @@
// Short queue between front and back end.
// Depends on hlt_pkg.
module hlt_queue import hlt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_data_i,
  input  logic idle_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_data_o
);
  logic full_q, full_d;
  cmd_t data_q;
  // one entry; refill only when back end is idle so budgets checked are current
  assign in_ready_o = !full_q && idle_i;
  assign out_valid_o = full_q;
  assign out_data_o = data_q;
  always_comb begin
    full_d = full_q;
    if (out_ready_i && full_q) full_d = 1'b0;
    if (in_valid_i && in_ready_o) full_d = 1'b1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) data_q <= in_data_i;
  end
endmodule

@@ rtl/hlt_back.sv @@
// Back end: scans the table one entry per cycle, applies the request,
// keeps the budgets and drives the response register. Depends on hlt_pkg.
module hlt_back import hlt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  input  logic [LimW-1:0]     lim_i [1:NumTypes-1],
  output logic [NumTypes-1:0] budget_zero_o,
  output logic                idle_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output rsp_t                rsp_o
);
  logic                used_q [TableDepth];
  logic [14:0]         own_q  [TableDepth];
  logic [1:0]          typ_q  [TableDepth];
  logic                exc_q  [TableDepth];
  logic [KeyBits-1:0]  key_q  [TableDepth];
  logic [LimW-1:0]     bud_q  [NumTypes];

  bstate_e state_q, state_d;
  cmd_t cmd_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic conflict_q, conflict_d, found_q, found_d, free_q, free_d;
  logic [IdxW-1:0] hit_q, hit_d, fslot_q, fslot_d;
  rsp_t rsp_q, rsp_d;
  logic rv_q, rv_d;

  logic [IdxW-1:0] e;
  logic key_eq, own_eq, clr_one, grant, rel1;
  assign e = idx_q[IdxW-1:0];
  assign key_eq = used_q[e] && key_q[e] == cmd_q.req.lock_key[KeyBits-1:0]
                  && typ_q[e] == cmd_q.req.lock_type;
  assign own_eq = used_q[e] && own_q[e] == cmd_q.req.owner_id;
  // release-all frees entries during the scan itself
  assign clr_one = state_q == BS_SCAN && cmd_q.req.kind == KIND_REL_ALL && own_eq;
  assign grant = state_q == BS_APPLY && cmd_q.req.kind == KIND_LOCK
                 && cmd_q.budget_ok && !conflict_q && free_q;
  assign rel1 = state_q == BS_APPLY && cmd_q.req.kind == KIND_REL_ONE && found_q;

  always_comb begin
    for (int t = 0; t < NumTypes; t++) budget_zero_o[t] = bud_q[t] == '0;
  end
  assign cmd_ready_o = state_q == BS_IDLE;
  assign idle_o = state_q == BS_IDLE && !rv_q;
  assign rsp_valid_o = rv_q;
  assign rsp_o = rsp_q;

  always_comb begin
    state_d = state_q; idx_d = idx_q; cnt_d = cnt_q;
    conflict_d = conflict_q; found_d = found_q; free_d = free_q;
    hit_d = hit_q; fslot_d = fslot_q; rsp_d = rsp_q; rv_d = rv_q;
    if (rv_q && rsp_ready_i) rv_d = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          state_d = BS_SCAN; idx_d = '0; cnt_d = '0;
          conflict_d = 1'b0; found_d = 1'b0; free_d = 1'b0;
        end
      end
      BS_SCAN: begin
        if (key_eq && (exc_q[e] || !cmd_q.req.lock_mode)) conflict_d = 1'b1;
        if (!found_q && key_eq && own_eq) begin
          found_d = 1'b1; hit_d = e;
        end
        if (!free_q && !used_q[e]) begin
          free_d = 1'b1; fslot_d = e;
        end
        if ((cmd_q.req.kind == KIND_ABORT && used_q[e]) || clr_one) cnt_d = cnt_q + 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == CntW'(TableDepth - 1)) state_d = BS_APPLY;
      end
      BS_APPLY: begin
        rsp_d = '0;
        case (kind_e'(cmd_q.req.kind))
          KIND_LOCK: begin
            if (grant) rsp_d.slot = 5'(fslot_q);
            else rsp_d.status = ST_REFUSED;
          end
          KIND_REL_ONE: begin
            if (found_q) begin
              rsp_d.slot = 5'(hit_q); rsp_d.freed_count = 6'd1;
            end else begin
              rsp_d.status = ST_NOT_HELD;
            end
          end
          default: rsp_d.freed_count = 6'(cnt_q);
        endcase
        state_d = BS_OUT;
      end
      BS_OUT: begin
        if (!rv_q) begin
          rv_d = 1'b1; state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE; rv_q <= 1'b0;
      idx_q <= '0; cnt_q <= '0; conflict_q <= 1'b0; found_q <= 1'b0; free_q <= 1'b0;
      hit_q <= '0; fslot_q <= '0; rsp_q <= '0;
      for (int i = 0; i < TableDepth; i++) begin
        used_q[i] <= 1'b0; own_q[i] <= '0; typ_q[i] <= '0;
        exc_q[i] <= 1'b0; key_q[i] <= '0;
      end
      bud_q[0] <= LimW'(TableDepth);
      for (int t = 1; t < NumTypes; t++) bud_q[t] <= LimW'(32);
    end else begin
      state_q <= state_d; rv_q <= rv_d; idx_q <= idx_d; cnt_q <= cnt_d;
      conflict_q <= conflict_d; found_q <= found_d; free_q <= free_d;
      hit_q <= hit_d; fslot_q <= fslot_d; rsp_q <= rsp_d;
      if (state_q == BS_IDLE && cmd_valid_i) cmd_q <= cmd_i;
      if (clr_one) begin
        used_q[e] <= 1'b0; own_q[e] <= '0;
        for (int t = 0; t < NumTypes; t++)
          if (t <= int'(typ_q[e])) bud_q[t] <= bud_q[t] + 1'b1;
      end
      if (grant) begin
        used_q[fslot_q] <= 1'b1; own_q[fslot_q] <= cmd_q.req.owner_id;
        typ_q[fslot_q] <= cmd_q.req.lock_type; exc_q[fslot_q] <= !cmd_q.req.lock_mode;
        key_q[fslot_q] <= cmd_q.req.lock_key[KeyBits-1:0];
        for (int t = 0; t < NumTypes; t++)
          if (t <= int'(cmd_q.req.lock_type)) bud_q[t] <= bud_q[t] - 1'b1;
      end
      if (rel1) begin
        used_q[hit_q] <= 1'b0; own_q[hit_q] <= '0;
        for (int t = 0; t < NumTypes; t++)
          if (t <= int'(typ_q[hit_q])) bud_q[t] <= bud_q[t] + 1'b1;
      end
      if (state_q == BS_APPLY && cmd_q.req.kind == KIND_ABORT) begin
        for (int i = 0; i < TableDepth; i++) begin
          used_q[i] <= 1'b0; own_q[i] <= '0; typ_q[i] <= '0;
          exc_q[i] <= 1'b0; key_q[i] <= '0;
        end
        bud_q[0] <= LimW'(TableDepth);
        for (int t = 1; t < NumTypes; t++) bud_q[t] <= lim_i[t];
      end
    end
  end
endmodule

@@ rtl/hierarchical_lock_table.sv @@
// Top level of the hierarchical lock table: front end, command queue, back end.
// Depends on hlt_pkg, hlt_if, hlt_front, hlt_queue, hlt_back.
//
// One request is handled at a time. The back end walks the 32-entry table one
// entry per cycle; a request passes through the queue register, the table scan,
// the apply state and the output state before its response is offered. The
// next request is accepted in the cycle after the response beat, not before.
// Limit registers take effect at the next abort; reset restores the default 32.
module hierarchical_lock_table import hlt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  hlt_req_if.sink      req,
  hlt_rsp_if.source    rsp,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [5:0]   cfg_data_i
);
  logic [LimW-1:0] lim_q [1:NumTypes-1];
  logic [NumTypes-1:0] bz;
  logic qi_valid, qi_ready, qo_valid, qo_ready, idle;
  cmd_t qi_data, qo_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 1; t < NumTypes; t++) lim_q[t] <= LimW'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PAGE: lim_q[1] <= cfg_data_i;
        CFG_REL:  lim_q[2] <= cfg_data_i;
        CFG_DB:   lim_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hlt_front u_front (
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .in_data_i(req.data), .budget_zero_i(bz), .q_ready_i(qi_ready),
    .q_valid_o(qi_valid), .q_data_o(qi_data)
  );
  hlt_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(qi_valid), .in_ready_o(qi_ready),
    .in_data_i(qi_data), .idle_i(idle), .out_valid_o(qo_valid),
    .out_ready_i(qo_ready), .out_data_o(qo_data)
  );
  hlt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(qo_valid), .cmd_ready_o(qo_ready),
    .cmd_i(qo_data), .lim_i(lim_q), .budget_zero_o(bz), .idle_o(idle),
    .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_o(rsp.data)
  );
endmodule

@@ rtl/hlt_checker.sv @@
// Port-level checker for the hierarchical lock table, bound to the top level.
// Depends on hlt_pkg.
module hlt_checker import hlt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i, input logic in_ready_i,
  input logic out_valid_i, input logic out_ready_i,
  input rsp_t out_data_i
);
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.status != 2'd3) else $error("bad status");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("second accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)) else $error("drop");
  a_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("accept with response pending");
endmodule

bind hierarchical_lock_table hlt_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(req.valid), .in_ready_i(req.ready),
  .out_valid_i(rsp.valid), .out_ready_i(rsp.ready), .out_data_i(rsp.data)
);
